[sv/slce_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package slce_pkg;

  localparam int WIN_DEPTH     = 15;
  localparam int TABLE_ENTRIES = 256;

  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_FLUSH = 2'd1;
  localparam logic [1:0] CMD_KEY   = 2'd2;
  localparam logic [1:0] CMD_ENTRY = 2'd3;

  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [3:0] key_position;
    logic [3:0] key_length;
    logic [7:0] code_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic       shift;
    logic [7:0] load_byte;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[sv/slce_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module slce_cell (
  input  wire logic               clk,
  input  wire slce_pkg::cell_ctrl_t ctrl,
  input  wire logic               load,
  input  wire logic               we,
  input  wire logic [7:0]         nxt,
  output logic [7:0]              win,
  output logic                    eq
);

  logic [7:0] mem [256];
  logic [7:0] rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[ctrl.waddr] <= ctrl.wdata;
    end
    rdata <= mem[ctrl.raddr];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      win <= ctrl.load_byte;
    end else if (ctrl.shift) begin
      win <= nxt;
    end
  end

  assign eq = (win == rdata);

endmodule
`default_nettype wire

[sv/string_literal_charmap_encoder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// Character map encoder for string literals in source text. Text bytes go into a
// 15-byte lookahead row of cells; once it is full, each word decides the head byte.
// Inside a literal the table entries are walked in index order, one entry per
// cycle (one read of the key lanes held in the cells), and the first matching
// entry gives the code byte; after each decided byte the row shifts out the
// consumed bytes. Table writes give no result. A flush decides every remaining
// byte in the same way.
module string_literal_charmap_encoder_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                src_valid,
  output logic                     src_ready,
  input  wire slce_pkg::in_word_t  src_word,
  output logic                     dst_valid,
  input  wire logic                dst_ready,
  output slce_pkg::out_word_t      dst_word,
  input  wire logic                cfg_we,
  input  wire logic [8:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECIDE = 4'b0010,
    S_SEARCH = 4'b0100,
    S_WAIT   = 4'b1000
  } state_t;

  state_t      state;
  logic [8:0]  entries_in_use;
  logic [3:0]  count;
  logic [3:0]  rem;
  logic        flushing;
  logic        at_ls, in_hash, in_lit, bs_odd;
  logic [8:0]  ea;
  logic        cmp_valid;
  logic [11:0] emem [256];
  logic [3:0]  len_q;
  logic [7:0]  code_q;

  slce_pkg::cell_ctrl_t ctrl;
  logic [7:0] win [slce_pkg::WIN_DEPTH];
  logic [7:0] nxt [slce_pkg::WIN_DEPTH];
  logic [slce_pkg::WIN_DEPTH-1:0] eq, load, we;

  logic        accept;
  logic [7:0]  head;
  logic        hash_n, lit_n, bs_n;
  logic [8:0]  limit;
  logic        all_eq, hit;

  assign accept    = src_valid && src_ready;
  assign src_ready = (state == S_IDLE);
  assign head      = win[0];
  assign limit     = (entries_in_use > 9'(slce_pkg::TABLE_ENTRIES)) ?
                     9'(slce_pkg::TABLE_ENTRIES) : entries_in_use;

  assign ctrl.shift     = (state == S_WAIT) && (rem != 4'd0);
  assign ctrl.load_byte = src_word.data_byte;
  assign ctrl.waddr     = src_word.entry_index;
  assign ctrl.wdata     = src_word.data_byte;
  assign ctrl.raddr     = ea[7:0];

  always_comb begin
    for (int i = 0; i < slce_pkg::WIN_DEPTH; i++) begin
      load[i] = accept && (src_word.cmd == slce_pkg::CMD_DATA) && (count == 4'(i));
      we[i]   = accept && (src_word.cmd == slce_pkg::CMD_KEY) &&
                (src_word.key_position == 4'(i));
      nxt[i]  = (i == slce_pkg::WIN_DEPTH - 1) ? 8'd0 : win[(i + 1) % slce_pkg::WIN_DEPTH];
    end
  end

  for (genvar g = 0; g < slce_pkg::WIN_DEPTH; g++) begin : g_cell
    slce_cell u_cell (
      .clk  (clk),
      .ctrl (ctrl),
      .load (load[g]),
      .we   (we[g]),
      .nxt  (nxt[g]),
      .win  (win[g]),
      .eq   (eq[g])
    );
  end

  always_ff @(posedge clk) begin
    if (accept && (src_word.cmd == slce_pkg::CMD_ENTRY)) begin
      emem[src_word.entry_index] <= {src_word.key_length, src_word.code_byte};
    end
    {len_q, code_q} <= emem[ea[7:0]];
  end

  always_comb begin
    all_eq = 1'b1;
    for (int i = 0; i < slce_pkg::WIN_DEPTH; i++) begin
      if (4'(i) < len_q && !eq[i]) begin
        all_eq = 1'b0;
      end
    end
    hit = cmp_valid && (len_q != 4'd0) && (len_q <= count) && all_eq;
  end

  always_comb begin
    hash_n = in_hash || (head == slce_pkg::CH_HASH && at_ls);
    lit_n  = in_lit;
    if (head == slce_pkg::CH_QUOTE) begin
      if (!in_lit) begin
        lit_n = !hash_n;
      end else if (!bs_odd) begin
        lit_n = 1'b0;
      end
    end
    bs_n = (head == slce_pkg::CH_BACKSLASH) ? !bs_odd : 1'b0;
    if (head == slce_pkg::CH_NEWLINE) begin
      hash_n = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      entries_in_use <= 9'd0;
      count          <= 4'd0;
      rem            <= 4'd0;
      flushing       <= 1'b0;
      at_ls          <= 1'b1;
      in_hash        <= 1'b0;
      in_lit         <= 1'b0;
      bs_odd         <= 1'b0;
      ea             <= 9'd0;
      cmp_valid      <= 1'b0;
      dst_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        entries_in_use <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (accept && src_word.cmd == slce_pkg::CMD_DATA) begin
            count <= count + 4'd1;
            if (count == 4'(slce_pkg::WIN_DEPTH - 1)) begin
              state <= S_DECIDE;
            end
          end else if (accept && src_word.cmd == slce_pkg::CMD_FLUSH) begin
            if (count == 4'd0) begin
              at_ls   <= 1'b1;
              in_hash <= 1'b0;
              in_lit  <= 1'b0;
              bs_odd  <= 1'b0;
            end else begin
              flushing <= 1'b1;
              state    <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          in_hash   <= hash_n;
          in_lit    <= lit_n;
          bs_odd    <= bs_n;
          at_ls     <= (head == slce_pkg::CH_NEWLINE);
          ea        <= 9'd0;
          cmp_valid <= 1'b0;
          if (lit_n) begin
            state <= S_SEARCH;
          end else begin
            dst_valid         <= 1'b1;
            dst_word.out_byte <= head;
            dst_word.last     <= !flushing || (count == 4'd1);
            rem               <= 4'd1;
            state             <= S_WAIT;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            dst_valid         <= 1'b1;
            dst_word.out_byte <= code_q;
            dst_word.last     <= !flushing || (count == len_q);
            bs_odd            <= 1'b0;
            rem               <= len_q;
            state             <= S_WAIT;
          end else if (ea < limit) begin
            ea        <= ea + 9'd1;
            cmp_valid <= 1'b1;
          end else begin
            dst_valid         <= 1'b1;
            dst_word.out_byte <= head;
            dst_word.last     <= !flushing || (count == 4'd1);
            rem               <= 4'd1;
            state             <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (dst_valid && dst_ready) begin
            dst_valid <= 1'b0;
          end
          if (rem != 4'd0) begin
            rem   <= rem - 4'd1;
            count <= count - 4'd1;
          end else if (!dst_valid || dst_ready) begin
            if (flushing && count != 4'd0) begin
              state <= S_DECIDE;
            end else begin
              state <= S_IDLE;
              if (flushing) begin
                flushing <= 1'b0;
                at_ls    <= 1'b1;
                in_hash  <= 1'b0;
                in_lit   <= 1'b0;
                bs_odd   <= 1'b0;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_out_in_wait: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> state == S_WAIT)
    else $error("result word outside wait state");

  a_search_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> count != 4'd0)
    else $error("search with empty window");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 4'(slce_pkg::WIN_DEPTH))
    else $error("window count overflow");

  a_emit_shift: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && hit) |=> rem != 4'd0 && dst_valid)
    else $error("hit without consume");

endmodule
`default_nettype wire
